>>> rtl/fwu_pkg.sv
// Shared types and constants for the firmware update session tracker.
// No dependencies; imported by firmware_update_session_tracker_top.
package fwu_pkg;

	localparam int unsigned MAX_PAYLOAD = 200;
	localparam int unsigned MIN_HEADER  = 24;

	localparam int unsigned SIZE_W   = 25;
	localparam int unsigned IN_DATA_W  = 200;
	localparam int unsigned OUT_DATA_W = 96;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [SIZE_W-1:0] PARTITION_SIZE_RST = 25'd1572864;
	localparam logic [7:0]        IMAGE_MAGIC_RST    = 8'd233;
	localparam logic [15:0]       EXPECTED_CHIP_RST  = 16'd9;

	typedef enum logic [2:0] {
		FN_PROBE  = 3'd0,
		FN_BEGIN  = 3'd1,
		FN_DATA   = 3'd2,
		FN_END    = 3'd3,
		FN_ABORT  = 3'd4,
		FN_REBOOT = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_PACKET  = 3'd1,
		ST_BAD_STATE   = 3'd2,
		ST_BAD_IMAGE   = 3'd3,
		ST_FLASH_ERROR = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PARTITION_SIZE = 2'd0,
		REG_IMAGE_MAGIC    = 2'd1,
		REG_EXPECTED_CHIP  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]        func;
		logic [31:0]       session_id;
		logic [31:0]       seq_num;
		logic [31:0]       arg_value;
		logic [7:0]        block_len;
		logic [31:0]       claimed_crc;
		logic [31:0]       computed_crc;
		logic [7:0]        head_magic;
		logic [15:0]       head_chip;
		logic              open_ok;
		logic              store_ok;
		logic              close_ok;
	} req_t;

	typedef struct packed {
		logic              active;
		logic [31:0]       cur_session;
		logic [31:0]       next_seq;
		logic [SIZE_W-1:0] image_bytes;
		logic [SIZE_W-1:0] written;
		logic [31:0]       prev_crc;
		logic [7:0]        prev_len;
	} sess_t;

	typedef struct packed {
		status_t           status;
		logic [2:0]        echo_func;
		logic [31:0]       echo_session;
		logic [31:0]       echo_seq;
		logic [SIZE_W-1:0] bytes_written;
		logic              commit_block;
		logic              session_abort;
		logic              restart_req;
	} reply_t;

endpackage

>>> rtl/firmware_update_session_tracker_top.sv
// Firmware update session tracker, receiver side: one status reply per request.
// Depends on fwu_pkg for request, session and reply types.
//
// Use:
//   Requests enter on the s_ group: s_tuser carries the request kind, s_tdata
//   the remaining decoded fields. Replies leave on the m_ group: m_tuser
//   echoes the request kind, m_tdata holds status, echoes, byte count and
//   the commit, abort and restart strobes. Configuration registers are
//   written on the cfg_ channel, which is always ready; write them only
//   while no request is in flight.
// Pipeline and throughput:
//   A request beat is registered, then checked against the session state and
//   written to the reply register. One request per cycle is sustained while
//   m_tready stays high, since each check is a compare or a single 26-bit add
//   against registered state.
// Reset:
//   arst_n clears the session (inactive, all counters zero), loads the
//   configuration defaults and empties both pipeline stages.
// Stall:
//   While the reply waits on m_tready, the request stage holds; s_tready
//   drops only once both stages are full.
module firmware_update_session_tracker_top
	import fwu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [31:0] session_id, [63:32] seq_num, [95:64] arg_value, [103:96] block_len,
	// [135:104] claimed_crc, [167:136] computed_crc, [175:168] head_magic,
	// [191:176] head_chip, [192] open_ok, [193] store_ok, [194] close_ok, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [2:0] func
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] status, [34:3] echo_session, [66:35] echo_seq, [91:67] bytes_written,
	// [92] commit_block, [93] session_abort, [94] restart_req, [95] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [2:0] echo_func
	output logic [2:0]            m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0]     cfg_data
);

	logic              s1_valid;
	req_t              req_s1;
	logic              out_valid_q;
	reply_t            reply_q;
	sess_t             sess_q;
	sess_t             sess_d;
	reply_t            reply_d;
	logic [SIZE_W-1:0] partition_size_q;
	logic [7:0]        image_magic_q;
	logic [15:0]       expected_chip_q;

	logic              advance;
	logic              in_beat;
	logic              work;

	logic              sess_match;
	logic              len_bad;
	logic              is_retry;
	logic [SIZE_W:0]   written_sum;
	logic              header_bad;
	sess_t             begin_base;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !s1_valid || advance;
	assign in_beat   = s_tvalid && s_tready;
	assign work      = s1_valid && advance;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partition_size_q <= PARTITION_SIZE_RST;
			image_magic_q    <= IMAGE_MAGIC_RST;
			expected_chip_q  <= EXPECTED_CHIP_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PARTITION_SIZE: partition_size_q <= cfg_data;
				REG_IMAGE_MAGIC:    image_magic_q    <= cfg_data[7:0];
				REG_EXPECTED_CHIP:  expected_chip_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			req_s1.func         <= s_tuser;
			req_s1.session_id   <= s_tdata[31:0];
			req_s1.seq_num      <= s_tdata[63:32];
			req_s1.arg_value    <= s_tdata[95:64];
			req_s1.block_len    <= s_tdata[103:96];
			req_s1.claimed_crc  <= s_tdata[135:104];
			req_s1.computed_crc <= s_tdata[167:136];
			req_s1.head_magic   <= s_tdata[175:168];
			req_s1.head_chip    <= s_tdata[191:176];
			req_s1.open_ok      <= s_tdata[192];
			req_s1.store_ok     <= s_tdata[193];
			req_s1.close_ok     <= s_tdata[194];
		end
	end

	// request checks
	assign sess_match  = sess_q.active && (req_s1.session_id == sess_q.cur_session);
	assign len_bad     = (req_s1.block_len == 8'd0) ||
	                     (req_s1.block_len > 8'(MAX_PAYLOAD));
	assign is_retry    = (sess_q.next_seq != 32'd0) &&
	                     (req_s1.seq_num == sess_q.next_seq - 32'd1) &&
	                     (req_s1.block_len == sess_q.prev_len) &&
	                     (req_s1.claimed_crc == sess_q.prev_crc);
	assign written_sum = {1'b0, sess_q.written} + {(SIZE_W+1-8)'(0), req_s1.block_len};
	assign header_bad  = (sess_q.written == '0) &&
	                     ((req_s1.block_len < 8'(MIN_HEADER)) ||
	                      (req_s1.head_magic != image_magic_q) ||
	                      (req_s1.head_chip != expected_chip_q));
	// a begin over a live session starts from a cleared one
	assign begin_base  = sess_q.active ? '0 : sess_q;

	always_comb begin
		sess_d                = sess_q;
		reply_d.status        = ST_OK;
		reply_d.echo_func     = req_s1.func;
		reply_d.echo_session  = req_s1.session_id;
		reply_d.echo_seq      = req_s1.seq_num;
		reply_d.commit_block  = 1'b0;
		reply_d.session_abort = 1'b0;
		reply_d.restart_req   = 1'b0;
		unique case (req_s1.func)
			FN_PROBE: ;
			FN_BEGIN: begin
				sess_d                = begin_base;
				reply_d.session_abort = sess_q.active;
				if (req_s1.arg_value == 32'd0 ||
				    req_s1.arg_value > {(32-SIZE_W)'(0), partition_size_q}) begin
					reply_d.status = ST_BAD_IMAGE;
				end else if (!req_s1.open_ok) begin
					sess_d         = '0;
					reply_d.status = ST_FLASH_ERROR;
				end else begin
					sess_d.active      = 1'b1;
					sess_d.cur_session = req_s1.session_id;
					sess_d.image_bytes = req_s1.arg_value[SIZE_W-1:0];
					sess_d.next_seq    = '0;
					sess_d.written     = '0;
				end
			end
			FN_DATA: begin
				if (!sess_match) begin
					reply_d.status = ST_BAD_STATE;
				end else if (len_bad || req_s1.computed_crc != req_s1.claimed_crc) begin
					reply_d.status = ST_BAD_PACKET;
				end else if (is_retry) begin
					reply_d.status = ST_OK;
				end else if (req_s1.seq_num != sess_q.next_seq) begin
					reply_d.status = ST_BAD_STATE;
				end else if (written_sum > {1'b0, sess_q.image_bytes}) begin
					reply_d.status = ST_BAD_PACKET;
				end else if (header_bad) begin
					reply_d.status = ST_BAD_IMAGE;
				end else if (!req_s1.store_ok) begin
					sess_d                = '0;
					reply_d.session_abort = 1'b1;
					reply_d.status        = ST_FLASH_ERROR;
				end else begin
					sess_d.written       = written_sum[SIZE_W-1:0];
					sess_d.prev_crc      = req_s1.claimed_crc;
					sess_d.prev_len      = req_s1.block_len;
					sess_d.next_seq      = sess_q.next_seq + 32'd1;
					reply_d.commit_block = 1'b1;
				end
			end
			FN_END: begin
				if (!sess_match || sess_q.written != sess_q.image_bytes) begin
					reply_d.status = ST_BAD_STATE;
				end else if (!req_s1.close_ok) begin
					sess_d         = '0;
					reply_d.status = ST_BAD_IMAGE;
				end else begin
					sess_d.active = 1'b0;
				end
			end
			FN_ABORT: begin
				sess_d                = '0;
				reply_d.session_abort = sess_q.active;
			end
			FN_REBOOT: reply_d.restart_req = 1'b1;
			default:   reply_d.status = ST_BAD_PACKET;
		endcase
		reply_d.bytes_written = sess_d.written;
	end

	// session state and reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
			if (s1_valid) begin
				sess_q <= sess_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			reply_q <= reply_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = reply_q.echo_func;
	assign m_tdata  = {1'b0, reply_q.restart_req, reply_q.session_abort, reply_q.commit_block,
	                   reply_q.bytes_written, reply_q.echo_seq, reply_q.echo_session,
	                   reply_q.status};

	// checks
	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && reply_q.commit_block |-> reply_q.status == ST_OK)
		else $error("commit strobe on a failed reply");

	a_restart_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && reply_q.restart_req |-> reply_q.echo_func == FN_REBOOT)
		else $error("restart strobe on a non-reboot reply");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		sess_q.active |-> sess_q.written <= sess_q.image_bytes)
		else $error("bytes written exceed image size");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid && out_valid_q && !m_tready)
		else $error("request side stalled with room in the pipeline");

	a_idle_state_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid |=> $stable(sess_q))
		else $error("session state changed without a request");

endmodule

>>> dv/firmware_update_session_tracker_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for firmware_update_session_tracker_top: directed and random
// requests, with a scoreboard class that predicts every reply. Depends on fwu_pkg.
module firmware_update_session_tracker_top_tb;
	import fwu_pkg::*;

	localparam logic [2:0] FN_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] FN_UNKNOWN_HI = 3'd7;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	class fwu_scoreboard;
		logic [SIZE_W-1:0] part_size;
		logic [7:0]        hdr_magic;
		logic [15:0]       hdr_chip;
		logic              active;
		logic [31:0]       cur_session;
		logic [31:0]       next_seq;
		logic [SIZE_W-1:0] image_bytes;
		logic [SIZE_W-1:0] written;
		logic [31:0]       prev_crc;
		logic [7:0]        prev_len;
		reply_t            replies_due[$];
		int unsigned       errors, checked, noted, commits, closes;

		function new();
			part_size = PARTITION_SIZE_RST;
			hdr_magic = IMAGE_MAGIC_RST;
			hdr_chip  = EXPECTED_CHIP_RST;
			clear_session();
		endfunction

		function void clear_session();
			active      = 1'b0;
			cur_session = '0;
			next_seq    = '0;
			image_bytes = '0;
			written     = '0;
			prev_crc    = '0;
			prev_len    = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [SIZE_W-1:0] val);
			case (idx)
				REG_PARTITION_SIZE: part_size = val;
				REG_IMAGE_MAGIC:    hdr_magic = val[7:0];
				REG_EXPECTED_CHIP:  hdr_chip  = val[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		// Advance the session state by one request and queue the reply it earns.
		function void predict_reply(req_t r);
			reply_t            e;
			logic [SIZE_W:0]   sum;
			e = '0;
			e.status       = ST_OK;
			e.echo_func    = r.func;
			e.echo_session = r.session_id;
			e.echo_seq     = r.seq_num;
			sum = written + r.block_len;
			case (r.func)
				FN_PROBE: ;
				FN_BEGIN: begin
					if (active) begin
						e.session_abort = 1'b1;
						clear_session();
					end
					if (r.arg_value == 0 || r.arg_value > part_size) begin
						e.status = ST_BAD_IMAGE;
					end else if (!r.open_ok) begin
						clear_session();
						e.status = ST_FLASH_ERROR;
					end else begin
						active      = 1'b1;
						cur_session = r.session_id;
						image_bytes = r.arg_value[SIZE_W-1:0];
						next_seq    = '0;
						written     = '0;
					end
				end
				FN_DATA: begin
					if (!active || r.session_id != cur_session) begin
						e.status = ST_BAD_STATE;
					end else if (r.block_len == 0 || r.block_len > MAX_PAYLOAD) begin
						e.status = ST_BAD_PACKET;
					end else if (r.computed_crc != r.claimed_crc) begin
						e.status = ST_BAD_PACKET;
					end else if (next_seq != 0 && r.seq_num == next_seq - 32'd1 &&
					             r.block_len == prev_len && r.claimed_crc == prev_crc) begin
						// retried copy of the last block: acknowledge, no write
						e.status = ST_OK;
					end else if (r.seq_num != next_seq) begin
						e.status = ST_BAD_STATE;
					end else if (sum > image_bytes) begin
						e.status = ST_BAD_PACKET;
					end else if (written == 0 && (r.block_len < MIN_HEADER ||
					             r.head_magic != hdr_magic || r.head_chip != hdr_chip)) begin
						e.status = ST_BAD_IMAGE;
					end else if (!r.store_ok) begin
						e.session_abort = 1'b1;
						clear_session();
						e.status = ST_FLASH_ERROR;
					end else begin
						written  = sum[SIZE_W-1:0];
						prev_crc = r.claimed_crc;
						prev_len = r.block_len;
						next_seq = next_seq + 32'd1;
						e.commit_block = 1'b1;
						commits++;
					end
				end
				FN_END: begin
					if (!active || r.session_id != cur_session || written != image_bytes) begin
						e.status = ST_BAD_STATE;
					end else begin
						active = 1'b0;
						if (!r.close_ok) begin
							clear_session();
							e.status = ST_BAD_IMAGE;
						end else begin
							closes++;
						end
					end
				end
				FN_ABORT: begin
					if (active) e.session_abort = 1'b1;
					clear_session();
				end
				FN_REBOOT: e.restart_req = 1'b1;
				default: e.status = ST_BAD_PACKET;
			endcase
			e.bytes_written = written;
			replies_due.push_back(e);
			noted++;
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40) $display("[%0t] ERROR reply %0d: %s", $time, checked, what);
		endtask

		task check_reply(logic [OUT_DATA_W-1:0] d, logic [2:0] fn);
			reply_t e;
			checked++;
			if (replies_due.size() == 0) begin
				report("reply beat with no request outstanding");
				return;
			end
			e = replies_due.pop_front();
			if (d[2:0] !== e.status)
				report($sformatf("status %0d, want %0d", d[2:0], e.status));
			if (fn !== e.echo_func)
				report($sformatf("echo_func %0d, want %0d", fn, e.echo_func));
			if (d[34:3] !== e.echo_session)
				report($sformatf("echo_session %h, want %h", d[34:3], e.echo_session));
			if (d[66:35] !== e.echo_seq)
				report($sformatf("echo_seq %h, want %h", d[66:35], e.echo_seq));
			if (d[91:67] !== e.bytes_written)
				report($sformatf("bytes_written %0d, want %0d", d[91:67], e.bytes_written));
			if (d[92] !== e.commit_block)
				report($sformatf("commit_block %b, want %b", d[92], e.commit_block));
			if (d[93] !== e.session_abort)
				report($sformatf("session_abort %b, want %b", d[93], e.session_abort));
			if (d[94] !== e.restart_req)
				report($sformatf("restart_req %b, want %b", d[94], e.restart_req));
			if (d[95] !== 1'b0)
				report("pad bit 95 set");
		endtask
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [2:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_PARTITION_SIZE;
	logic [SIZE_W-1:0]     cfg_data  = '0;
	logic                  hold_off_go = 1'b0;

	fwu_scoreboard sb;
	int unsigned   burst_left = 0;
	int unsigned   cfg_writes = 0;
	int unsigned   idle_cycles = 0;

	firmware_update_session_tracker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [IN_DATA_W-1:0] pack_req(req_t r);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[31:0]    = r.session_id;
		d[63:32]   = r.seq_num;
		d[95:64]   = r.arg_value;
		d[103:96]  = r.block_len;
		d[135:104] = r.claimed_crc;
		d[167:136] = r.computed_crc;
		d[175:168] = r.head_magic;
		d[191:176] = r.head_chip;
		d[192]     = r.open_ok;
		d[193]     = r.store_ok;
		d[194]     = r.close_ok;
		return d;
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.func         = 3'($urandom_range(7));
		r.session_id   = $urandom;
		r.seq_num      = $urandom;
		r.arg_value    = $urandom;
		r.block_len    = 8'($urandom_range(255));
		r.claimed_crc  = $urandom;
		r.computed_crc = $urandom;
		r.head_magic   = 8'($urandom_range(255));
		r.head_chip    = 16'($urandom_range(65535));
		r.open_ok      = 1'($urandom_range(1));
		r.store_ok     = 1'($urandom_range(1));
		r.close_ok     = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic req_t ctl_req(logic [2:0] fn, logic [31:0] sess, logic [31:0] arg);
		req_t r;
		r = random_req();
		r.func      = fn;
		r.session_id = sess;
		r.arg_value = arg;
		r.open_ok   = 1'b1;
		r.store_ok  = 1'b1;
		r.close_ok  = 1'b1;
		return r;
	endfunction

	// Well-formed data block with a valid header for the current configuration.
	function automatic req_t data_req(logic [31:0] sess, logic [31:0] seq, int unsigned len);
		req_t r;
		r = ctl_req(FN_DATA, sess, $urandom);
		r.seq_num      = seq;
		r.block_len    = 8'(len);
		r.computed_crc = r.claimed_crc;
		r.head_magic   = sb.hdr_magic;
		r.head_chip    = sb.hdr_chip;
		return r;
	endfunction

	// Mostly sessions that make progress; the rest noise and broken blocks.
	function automatic req_t pick_request();
		req_t        r;
		int unsigned roll, room, hi, len, lim;
		r = random_req();
		roll = $urandom_range(99);
		if (roll < 12) return r;
		if (roll < 18) begin
			case ($urandom_range(3))
				0: r.func = FN_PROBE;
				1: r.func = FN_REBOOT;
				2: r.func = FN_ABORT;
				default: begin
					r.func = FN_END;
					r.session_id = sb.cur_session;
				end
			endcase
			return r;
		end
		if (!sb.active) begin
			r = ctl_req(FN_BEGIN, $urandom, 0);
			r.open_ok = ($urandom_range(24) != 0);
			lim = (sb.part_size < 800) ? sb.part_size : 800;
			case ($urandom_range(19))
				0: r.arg_value = '0;
				1: r.arg_value = 32'(sb.part_size);
				2: r.arg_value = 32'(sb.part_size) + 32'd1;
				default: r.arg_value = (lim < MIN_HEADER) ? 32'(lim) :
				                       32'($urandom_range(lim, MIN_HEADER));
			endcase
			return r;
		end
		if (sb.written == sb.image_bytes) begin
			r = ctl_req(FN_END, sb.cur_session, $urandom);
			r.close_ok = ($urandom_range(14) != 0);
			return r;
		end
		room = sb.image_bytes - sb.written;
		hi = (room < MAX_PAYLOAD) ? room : MAX_PAYLOAD;
		if (sb.written == 0 && hi >= MIN_HEADER) len = $urandom_range(hi, MIN_HEADER);
		else if ($urandom_range(2) == 0) len = hi;
		else len = $urandom_range(hi, 1);
		r = data_req(sb.cur_session, sb.next_seq, len);
		r.store_ok = ($urandom_range(39) != 0);
		if (roll >= 88) begin
			case ($urandom_range(5))
				0: r.seq_num = ($urandom_range(1)) ? sb.next_seq - 32'd1 :
				               sb.next_seq + 32'($urandom_range(3, 1));
				1: r.computed_crc = r.claimed_crc ^ (32'd1 << $urandom_range(31));
				2: r.block_len = ($urandom_range(1)) ? 8'd0 :
				                 8'($urandom_range(255, MAX_PAYLOAD + 1));
				3: r.session_id = sb.cur_session ^ (32'd1 << $urandom_range(31));
				4: if (sb.next_seq != 0) begin
					r.seq_num      = sb.next_seq - 32'd1;
					r.block_len    = sb.prev_len;
					r.claimed_crc  = sb.prev_crc;
					r.computed_crc = sb.prev_crc;
				end
				default: begin
					r.head_magic = r.head_magic ^ 8'(1 << $urandom_range(7));
					r.head_chip  = r.head_chip ^ 16'(1 << $urandom_range(15));
				end
			endcase
		end
		return r;
	endfunction

	// Send one request beat; bursts of random length separated by random gaps.
	task automatic send_req(req_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata  <= pack_req(r);
		s_tuser  <= r.func;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.predict_reply(r);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [SIZE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic configure(logic [SIZE_W-1:0] psize, logic [7:0] mg, logic [15:0] chip);
		write_reg(REG_PARTITION_SIZE, psize);
		write_reg(REG_IMAGE_MAGIC, SIZE_W'(mg));
		write_reg(REG_EXPECTED_CHIP, SIZE_W'(chip));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int unsigned n);
		repeat (n) send_req(pick_request());
	endtask

	task automatic run_directed();
		req_t        r;
		logic [31:0] s1, s2, s3;
		s1 = 32'h8000_0001;
		s2 = 32'h0000_0000;
		s3 = 32'hFFFF_FFFF;
		r = ctl_req(FN_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		r.seq_num = 32'hFFFF_FFFF;
		send_req(r);
		send_req(data_req(s1, 0, MIN_HEADER));
		send_req(ctl_req(FN_END, 0, 0));
		send_req(ctl_req(FN_ABORT, 0, 0));
		send_req(ctl_req(FN_BEGIN, s1, 0));
		send_req(ctl_req(FN_BEGIN, s1, 32'(PARTITION_SIZE_RST) + 32'd1));
		r = ctl_req(FN_BEGIN, s1, 300);
		r.open_ok = 1'b0;
		send_req(r);
		send_req(ctl_req(FN_BEGIN, s1, 300));
		send_req(data_req(s1 ^ 32'd1, 0, 100));
		send_req(data_req(s1, 0, 0));
		send_req(data_req(s1, 0, MAX_PAYLOAD + 1));
		r = data_req(s1, 0, 100);
		r.computed_crc = ~r.claimed_crc;
		send_req(r);
		send_req(data_req(s1, 1, 100));
		send_req(data_req(s1, 0, MIN_HEADER - 1));
		r = data_req(s1, 0, 100);
		r.head_magic = ~r.head_magic;
		send_req(r);
		r = data_req(s1, 0, 100);
		r.head_chip = r.head_chip ^ 16'h8000;
		send_req(r);
		// commit the first block, then retry the same copy
		r = data_req(s1, 0, MAX_PAYLOAD);
		send_req(r);
		send_req(r);
		send_req(data_req(s1, 1, 101));
		send_req(ctl_req(FN_END, s1, 0));
		send_req(data_req(s1, 1, 100));
		r = ctl_req(FN_END, s1, 0);
		r.close_ok = 1'b0;
		send_req(r);
		send_req(ctl_req(FN_BEGIN, s2, 32'(PARTITION_SIZE_RST)));
		send_req(ctl_req(FN_BEGIN, s2, 48));
		r = data_req(s2, 0, 48);
		r.store_ok = 1'b0;
		send_req(r);
		send_req(ctl_req(FN_BEGIN, s3, MIN_HEADER));
		r = data_req(s3, 0, MIN_HEADER);
		send_req(r);
		send_req(ctl_req(FN_END, s3, 0));
		// fresh session keeps the last block's length and CRC: no retry at seq -1
		send_req(ctl_req(FN_BEGIN, s3, 30));
		r.seq_num = 32'hFFFF_FFFF;
		send_req(r);
		send_req(ctl_req(FN_ABORT, s3, 0));
		send_req(ctl_req(FN_REBOOT, s3, 0));
		send_req(ctl_req(FN_UNKNOWN_LO, s1, 0));
		send_req(ctl_req(FN_UNKNOWN_HI, s1, 0));
	endtask

	// Reply side: check each beat, stall on a pattern of its own.
	initial begin
		int unsigned mode, mode_left, hold_left;
		bit          hold_taken;
		logic        rdy;
		mode_left  = 0;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_reply(m_tdata, m_tuser);
			if (hold_off_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_OFF_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(3);
				mode_left = $urandom_range(200, 20);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(1));
					2: rdy = (mode_left % 4 == 0);
					default: rdy = ($urandom_range(3) == 0);
				endcase
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d replies outstanding",
			         IDLE_LIMIT, sb.pending());
			$display("firmware_update_session_tracker_top: mismatch");
			$finish;
		end
	end

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		drain();
		configure(25'd16777216, 8'd0, 16'd0);
		run_random(350);
		drain();
		configure(25'd0, 8'd255, 16'd65535);
		run_random(100);
		drain();
		// long reply stall here: both stages fill and the request side backs up
		configure(25'd1000, 8'd255, 16'd65535);
		hold_off_go <= 1'b1;
		run_random(350);
		drain();
		configure(SIZE_W'($urandom_range(4000, MIN_HEADER)), 8'($urandom_range(255)),
		          16'($urandom_range(65535)));
		run_random(300);
		drain();
		configure(PARTITION_SIZE_RST, IMAGE_MAGIC_RST, EXPECTED_CHIP_RST);
		run_random(250);
		drain();
		repeat (10) @(posedge clk);
		$display("run: %0d requests, %0d replies checked, %0d register writes",
		         sb.noted, sb.checked, cfg_writes);
		$display("run: %0d blocks committed, %0d images closed, %0d errors",
		         sb.commits, sb.closes, sb.errors);
		if (sb.errors == 0)
			$display("firmware_update_session_tracker_top: match");
		else
			$display("firmware_update_session_tracker_top: mismatch");
		$finish;
	end

endmodule

>>> firmware_update_session_tracker_top.f
rtl/fwu_pkg.sv
rtl/firmware_update_session_tracker_top.sv
dv/firmware_update_session_tracker_top_tb.sv
